>>> rtl/rgcb_pkg.sv
// shared types, constants and helpers of the rotated glyph column blitter
`default_nettype none

package rgcb_pkg;

    // geometry and store sizing
    localparam int FRAME_WIDTH  = 480;
    localparam int GLYPH_COUNT  = 96;
    localparam int MAX_GLYPH_W  = 16;
    localparam int MAX_GLYPH_H  = 32;
    localparam int STORE_DEPTH  = GLYPH_COUNT * MAX_GLYPH_W;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int GLYPH_IDX_W  = $clog2(GLYPH_COUNT);
    localparam int WIDTH_CAP    = (MAX_GLYPH_W < 16) ? MAX_GLYPH_W : 16;
    localparam int HEIGHT_CAP   = (MAX_GLYPH_H < 32) ? MAX_GLYPH_H : 32;
    localparam int ADDR_W       = 19;

    // character codes
    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd127;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEXT_COLOR   = 2'd0,
        CFG_CLIP_X       = 2'd1,
        CFG_GLYPH_WIDTH  = 2'd2,
        CFG_GLYPH_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [3:0]  column_index;
        logic [31:0] column_bits;
        logic [9:0]  start_x;
        logic [8:0]  start_y;
        logic        first_of_string;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] column_address;
        logic [31:0]       column_mask;
        logic [15:0]       color_565;
        logic              last_column;
    } t_out_item;

    typedef struct packed {
        logic [31:0] text_color;
        logic [10:0] clip_x;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
    } t_cfg;

    // access request from the sequencer to the glyph store
    typedef struct packed {
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [31:0]         wr_data;
    } t_store_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_seq_state;

    // argb8888 to rgb565
    function automatic logic [15:0] to_565(input logic [31:0] argb);
        return {argb[23:19], argb[15:10], argb[7:3]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/rgcb_glyph_store.sv
// glyph column mask memory with a clearing sweep after reset
`default_nettype none

module rgcb_glyph_store (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rgcb_pkg::t_store_req  i_req,
    output logic [31:0]           o_rd_data,
    output logic                  o_clr_busy
);
    import rgcb_pkg::*;

    logic [31:0]         mem [STORE_DEPTH];
    logic [31:0]         r_rd_data;
    logic                r_clr_busy;
    logic [STORE_AW-1:0] r_clr_addr;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [31:0]         wr_data;

    // clearing sweep, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == STORE_AW'(STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write source select
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_req.wr_en;
            wr_addr = i_req.wr_addr;
            wr_data = i_req.wr_data;
        end
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

>>> rtl/rgcb_column_seq.sv
// draw sequencer: clip check, address stepping and output register
`default_nettype none

module rgcb_column_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rgcb_pkg::t_cfg        i_cfg,
    input  wire                   i_clr_busy,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  rgcb_pkg::t_in_item    i_in_item,
    output rgcb_pkg::t_store_req  o_store_req,
    input  wire [31:0]            i_rd_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output rgcb_pkg::t_out_item   o_out_item
);
    import rgcb_pkg::*;

    t_seq_state              r_state;
    t_seq_state              n_state;
    logic [10:0]             r_pen;
    logic [8:0]              r_line;
    logic [STORE_AW-1:0]     r_glyph_base;
    logic [4:0]              r_col;
    logic [4:0]              r_w;
    logic [31:0]             r_hmask;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_accept;
    logic                    is_draw;
    logic [7:0]              code_fix;
    logic [GLYPH_IDX_W-1:0]  glyph_idx;
    logic [4:0]              eff_w;
    logic [5:0]              eff_h;
    logic [11:0]             pen_end;
    logic                    clipped;
    logic [ADDR_W-1:0]       base_addr;
    logic                    out_free;
    logic                    last_col;
    logic [4:0]              col_next;

    // input is taken only while idle and the store is cleared
    assign o_in_stall = i_clr_busy || (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_draw    = (i_in_item.action == ACT_DRAW);

    // fallback for codes without a glyph
    always_comb begin
        if (i_in_item.char_code < FIRST_CODE || i_in_item.char_code > LAST_CODE) begin
            code_fix = FALLBACK_CODE;
        end else begin
            code_fix = i_in_item.char_code;
        end
    end
    assign glyph_idx = GLYPH_IDX_W'(code_fix - FIRST_CODE);

    // effective glyph size
    always_comb begin
        eff_w = i_cfg.glyph_width;
        if (eff_w == 5'd0) begin
            eff_w = 5'd1;
        end
        if (eff_w > 5'(WIDTH_CAP)) begin
            eff_w = 5'(WIDTH_CAP);
        end
        eff_h = i_cfg.glyph_height;
        if (eff_h == 6'd0) begin
            eff_h = 6'd1;
        end
        if (eff_h > 6'(HEIGHT_CAP)) begin
            eff_h = 6'(HEIGHT_CAP);
        end
    end

    // clip test and rotated base address of column zero
    assign pen_end   = {1'b0, r_pen} + 12'(eff_w);
    assign clipped   = pen_end > {1'b0, i_cfg.clip_x};
    assign base_addr = ADDR_W'(32'(r_pen) * 32'(FRAME_WIDTH))
                     + ADDR_W'(FRAME_WIDTH - 1) - ADDR_W'(r_line);

    assign out_free = !r_out_valid || !i_out_stall;
    assign last_col = (r_col + 5'd1 == r_w);
    assign col_next = r_col + 5'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && is_draw) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = clipped ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && last_col) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // store requests
    always_comb begin
        o_store_req.wr_en   = in_accept && !is_draw
                           && i_in_item.char_code >= FIRST_CODE
                           && i_in_item.char_code <= LAST_CODE
                           && (32'(i_in_item.column_index) < 32'(MAX_GLYPH_W));
        o_store_req.wr_addr = STORE_AW'(32'(glyph_idx) * 32'(MAX_GLYPH_W)
                                        + 32'(i_in_item.column_index));
        o_store_req.wr_data = i_in_item.column_bits;
        o_store_req.rd_en   = 1'b0;
        o_store_req.rd_addr = r_glyph_base;
        unique case (r_state)
            ST_SETUP: begin
                o_store_req.rd_en = !clipped;
            end
            ST_EMIT: begin
                o_store_req.rd_en   = out_free && !last_col;
                o_store_req.rd_addr = r_glyph_base + STORE_AW'(col_next);
            end
            default: begin
                o_store_req.rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pen       <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_accept && is_draw && i_in_item.first_of_string) begin
                r_pen  <= 11'(i_in_item.start_x);
                r_line <= i_in_item.start_y;
            end
            if (r_state == ST_SETUP && !clipped) begin
                r_pen <= pen_end[10:0];
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, shared address adder steps one column a transfer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && is_draw) begin
                    r_glyph_base <= STORE_AW'(32'(glyph_idx) * 32'(MAX_GLYPH_W));
                end
            end
            ST_SETUP: begin
                r_addr  <= base_addr;
                r_w     <= eff_w;
                r_col   <= '0;
                r_hmask <= 32'((33'd1 << eff_h) - 33'd1);
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out.column_address <= r_addr;
                    r_out.column_mask    <= i_rd_data & r_hmask;
                    r_out.color_565      <= to_565(i_cfg.text_color);
                    r_out.last_column    <= last_col;
                    r_col                <= col_next;
                    r_addr               <= r_addr + ADDR_W'(FRAME_WIDTH);
                end
            end
            default: begin
                r_col <= r_col;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // no result can exist before the store is cleared
    a_no_out_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_busy |-> !r_out_valid)
        else $error("result present during store clear");

    // column counter stays inside the glyph
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col < r_w))
        else $error("column counter beyond glyph width");

    // a column is not advanced while the output register is held
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !out_free) |=> $stable(r_addr) && $stable(r_col))
        else $error("column advanced while output held");

    // the final column of a glyph is flagged as the last column of the output
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && last_col) |=> (r_out_valid && r_out.last_column))
        else $error("final column not flagged");

endmodule

`default_nettype wire

>>> rtl/rotated_glyph_column_blitter.sv
// top level: configuration registers, glyph store and draw sequencer
`default_nettype none

// Rotated text blitter. A load transfer (action 0) writes one 32-bit glyph
// column into the glyph store. A draw transfer (action 1) produces one
// column write command per glyph column: a setup state does the clip test
// and base address multiply, then one column per cycle, unless the output
// stalls, goes through the shared address adder and the store's single read
// port. A clipped character gives no command. After reset the glyph store is
// swept to zero, one word per cycle; input is stalled meanwhile while
// configuration writes are still taken. Configuration should only be written
// while no draw is in flight.
module rotated_glyph_column_blitter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_index,
    input  wire [31:0]           i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  rgcb_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output rgcb_pkg::t_out_item  o_out_item
);
    import rgcb_pkg::*;

    t_cfg        r_cfg;
    t_store_req  store_req;
    logic [31:0] rd_data;
    logic        clr_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color   <= 32'hFFFF_FFFF;
            r_cfg.clip_x       <= 11'd1024;
            r_cfg.glyph_width  <= 5'd7;
            r_cfg.glyph_height <= 6'd12;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEXT_COLOR:   r_cfg.text_color   <= i_cfg_data;
                CFG_CLIP_X:       r_cfg.clip_x       <= i_cfg_data[10:0];
                CFG_GLYPH_WIDTH:  r_cfg.glyph_width  <= i_cfg_data[4:0];
                CFG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[5:0];
                default:          r_cfg.text_color   <= r_cfg.text_color;
            endcase
        end
    end

    rgcb_glyph_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

    rgcb_column_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clr_busy  (clr_busy),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_store_req (store_req),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
